[hw/rtl/bzp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzp_pkg
// Shared constants, tables and helpers of the pose-to-pose Bezier path core.
// ----------------------------------------------------------------------------
package bzp_pkg;

  localparam int POINTS       = 64;
  localparam int IDX_W        = $clog2(POINTS);
  localparam int COORD_W      = 32;
  localparam int CP_W         = 48;
  localparam int TRIG_W       = 34;
  localparam int CORDIC_STEPS = 24;
  localparam int CSTEP_W      = 5;
  localparam int LERP_W       = CP_W + IDX_W + 2;

  localparam logic [15:0]                GAIN_RESET = 16'd19661;
  localparam logic signed [TRIG_W-1:0]   CORDIC_K   = 34'sd652032874;
  localparam logic [IDX_W-1:0]           LAST_IDX   = IDX_W'(POINTS - 1);
  localparam logic signed [CP_W-1:0]     SAT_HI     = CP_W'((64'sd1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [CP_W-1:0]     SAT_LO     = -SAT_HI - CP_W'(1);

  // arctan(2^-k) in 2^32 units per turn
  function automatic logic signed [TRIG_W-1:0] atan_lut(input logic [CSTEP_W-1:0] k);
    logic signed [TRIG_W-1:0] v;
    case (k)
      5'd0:  v = 34'sh020000000;
      5'd1:  v = 34'sh012E4051E;
      5'd2:  v = 34'sh009FB385B;
      5'd3:  v = 34'sh0051111D4;
      5'd4:  v = 34'sh0028B0D43;
      5'd5:  v = 34'sh00145D7E1;
      5'd6:  v = 34'sh000A2F61E;
      5'd7:  v = 34'sh000517C55;
      5'd8:  v = 34'sh00028BE53;
      5'd9:  v = 34'sh000145F2F;
      5'd10: v = 34'sh0000A2F98;
      5'd11: v = 34'sh0000517CC;
      5'd12: v = 34'sh000028BE6;
      5'd13: v = 34'sh0000145F3;
      5'd14: v = 34'sh00000A2FA;
      5'd15: v = 34'sh00000517D;
      5'd16: v = 34'sh0000028BE;
      5'd17: v = 34'sh00000145F;
      5'd18: v = 34'sh000000A30;
      5'd19: v = 34'sh000000518;
      5'd20: v = 34'sh00000028C;
      5'd21: v = 34'sh000000146;
      5'd22: v = 34'sh0000000A3;
      5'd23: v = 34'sh000000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [CP_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/pose_to_pose_bezier_path_core.sv]
`timescale 1ns / 1ps
// Sequence: an accepted goal runs the 32-step square root and two 24-step
//   CORDIC passes in series before its first curve point.
// Points: each point then takes a reload, 6 shared lerp steps and the
//   output transaction; no new goal is taken until the last point is out.
// Reset: synchronous active-low rst_n clears the previous pose to zero and
//   loads tangent_gain with 0.3; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
// pose_to_pose_bezier_path_core
// Cubic Bezier path from the previous goal pose to the new one, sequenced
// over a shared multiplier, square root, CORDIC and lerp unit.
// ----------------------------------------------------------------------------
module pose_to_pose_bezier_path_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [15:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [31:0]                 in_goal_x,
  input  logic signed [31:0]                 in_goal_y,
  input  logic signed [15:0]                 in_goal_yaw,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bzp_pkg::COORD_W-1:0] out_point_x,
  output logic signed [bzp_pkg::COORD_W-1:0] out_point_y,
  output logic [bzp_pkg::IDX_W-1:0]          out_point_index,
  output logic                               out_last
);
  import bzp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQA, S_SQB, S_SQRT_GO, S_SQRT_WAIT, S_LEN, S_TRIG0_GO, S_TRIG0_WAIT,
    S_TRIG1_GO, S_TRIG1_WAIT, S_OFS, S_LOAD, S_LERP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0]               gain_r, gain_nxt;
  logic signed [31:0]        prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [15:0]               prev_yaw_r, prev_yaw_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [31:0]               ax_r, ax_nxt, ay_r, ay_nxt;
  logic [63:0]               a2_r, a2_nxt, b2_r, b2_nxt;
  logic signed [33:0]        len_r, len_nxt;
  logic [15:0]               yaw0_r, yaw0_nxt, yaw1_r, yaw1_nxt;
  logic signed [TRIG_W-1:0]  c0_r, c0_nxt, s0_r, s0_nxt, c1_r, c1_nxt, s1_r, s1_nxt;
  logic signed [CP_W-1:0]    p0x_r, p0x_nxt, p1x_r, p1x_nxt, p2x_r, p2x_nxt, p3x_r, p3x_nxt;
  logic signed [CP_W-1:0]    p0y_r, p0y_nxt, p1y_r, p1y_nxt, p2y_r, p2y_nxt, p3y_r, p3y_nxt;
  logic signed [CP_W-1:0]    w0x_r, w0x_nxt, w1x_r, w1x_nxt, w2x_r, w2x_nxt, w3x_r, w3x_nxt;
  logic signed [CP_W-1:0]    w0y_r, w0y_nxt, w1y_r, w1y_nxt, w2y_r, w2y_nxt, w3y_r, w3y_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [2:0]                step_r, step_nxt;
  logic [1:0]                ofs_k_r, ofs_k_nxt;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [IDX_W-1:0]          out_idx_r, out_idx_nxt;
  logic                      out_last_r, out_last_nxt;

  // shared multiplier
  logic signed [34:0]        mul_a, mul_b;
  logic signed [69:0]        mul_p;
  logic signed [CP_W-1:0]    ofs;

  logic signed [32:0]        dx, dy, adx, ady;
  logic [64:0]               sq_sum;
  logic [31:0]               root;
  logic                      sqrt_done;
  logic signed [TRIG_W-1:0]  cos_q, sin_q;
  logic                      trig_done;
  logic [15:0]               trig_angle;

  logic signed [CP_W-1:0]    lax, lbx, lay, lby, lrx, lry;

  function automatic logic signed [CP_W-1:0] lerp(input logic signed [CP_W-1:0] a,
                                                  input logic signed [CP_W-1:0] b,
                                                  input logic [IDX_W-1:0] i);
    logic signed [LERP_W-1:0] d;
    logic signed [LERP_W-1:0] p;
    logic signed [LERP_W-1:0] q;
    d = LERP_W'(b) - LERP_W'(a);
    p = d * signed'({{(LERP_W-IDX_W){1'b0}}, i});
    q = p / LERP_W'(POINTS);
    return a + q[CP_W-1:0];
  endfunction

  bzp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SQRT_GO),
    .radicand ({1'b0, sq_sum[64:2]}),
    .root     (root),
    .done     (sqrt_done)
  );

  assign trig_angle = (state_r == S_TRIG1_GO) ? yaw1_r : yaw0_r;

  bzp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == S_TRIG0_GO) || (state_r == S_TRIG1_GO)),
    .angle (trig_angle),
    .cos_q (cos_q),
    .sin_q (sin_q),
    .done  (trig_done)
  );

  assign dx     = 33'(in_goal_x) - 33'(prev_x_r);
  assign dy     = 33'(in_goal_y) - 33'(prev_y_r);
  assign adx    = dx[32] ? -dx : dx;
  assign ady    = dy[32] ? -dy : dy;
  assign sq_sum = {1'b0, a2_r} + {1'b0, b2_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQA: begin
        mul_a = signed'({3'b0, ax_r});
        mul_b = signed'({3'b0, ax_r});
      end
      S_SQB: begin
        mul_a = signed'({3'b0, ay_r});
        mul_b = signed'({3'b0, ay_r});
      end
      S_LEN: begin
        mul_a = signed'({19'b0, gain_r});
        mul_b = signed'({2'b0, root, 1'b0});
      end
      S_OFS: begin
        mul_a = 35'(len_r);
        case (ofs_k_r)
          2'd0:    mul_b = 35'(c0_r);
          2'd1:    mul_b = 35'(s0_r);
          2'd2:    mul_b = 35'(c1_r);
          default: mul_b = 35'(s1_r);
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign ofs   = CP_W'(mul_p >>> 30);

  // operand pairs of the six de Casteljau steps
  always_comb begin
    case (step_r)
      3'd1, 3'd4: begin
        lax = w1x_r; lbx = w2x_r; lay = w1y_r; lby = w2y_r;
      end
      3'd2: begin
        lax = w2x_r; lbx = w3x_r; lay = w2y_r; lby = w3y_r;
      end
      default: begin
        lax = w0x_r; lbx = w1x_r; lay = w0y_r; lby = w1y_r;
      end
    endcase
  end

  assign lrx = lerp(lax, lbx, idx_r);
  assign lry = lerp(lay, lby, idx_r);

  always_comb begin
    state_nxt     = state_r;
    gain_nxt      = gain_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_yaw_nxt  = prev_yaw_r;
    out_valid_nxt = out_valid_r;
    ax_nxt = ax_r;   ay_nxt = ay_r;   a2_nxt = a2_r;   b2_nxt = b2_r;
    len_nxt = len_r; yaw0_nxt = yaw0_r; yaw1_nxt = yaw1_r;
    c0_nxt = c0_r;   s0_nxt = s0_r;   c1_nxt = c1_r;   s1_nxt = s1_r;
    p0x_nxt = p0x_r; p1x_nxt = p1x_r; p2x_nxt = p2x_r; p3x_nxt = p3x_r;
    p0y_nxt = p0y_r; p1y_nxt = p1y_r; p2y_nxt = p2y_r; p3y_nxt = p3y_r;
    w0x_nxt = w0x_r; w1x_nxt = w1x_r; w2x_nxt = w2x_r; w3x_nxt = w3x_r;
    w0y_nxt = w0y_r; w1y_nxt = w1y_r; w2y_nxt = w2y_r; w3y_nxt = w3y_r;
    idx_nxt = idx_r; step_nxt = step_r; ofs_k_nxt = ofs_k_r;
    out_x_nxt = out_x_r; out_y_nxt = out_y_r;
    out_idx_nxt = out_idx_r; out_last_nxt = out_last_r;

    if (cfg_we) begin
      gain_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ax_nxt       = adx[31:0];
          ay_nxt       = ady[31:0];
          p0x_nxt      = CP_W'(prev_x_r);
          p0y_nxt      = CP_W'(prev_y_r);
          p3x_nxt      = CP_W'(in_goal_x);
          p3y_nxt      = CP_W'(in_goal_y);
          yaw0_nxt     = prev_yaw_r;
          yaw1_nxt     = in_goal_yaw;
          prev_x_nxt   = in_goal_x;
          prev_y_nxt   = in_goal_y;
          prev_yaw_nxt = in_goal_yaw;
          state_nxt    = S_SQA;
        end
      end
      S_SQA: begin
        a2_nxt    = mul_p[63:0];
        state_nxt = S_SQB;
      end
      S_SQB: begin
        b2_nxt    = mul_p[63:0];
        state_nxt = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        state_nxt = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        len_nxt   = signed'({1'b0, mul_p[48:16]});
        state_nxt = S_TRIG0_GO;
      end
      S_TRIG0_GO: begin
        state_nxt = S_TRIG0_WAIT;
      end
      S_TRIG0_WAIT: begin
        if (trig_done) begin
          c0_nxt    = cos_q;
          s0_nxt    = sin_q;
          state_nxt = S_TRIG1_GO;
        end
      end
      S_TRIG1_GO: begin
        state_nxt = S_TRIG1_WAIT;
      end
      S_TRIG1_WAIT: begin
        if (trig_done) begin
          c1_nxt    = cos_q;
          s1_nxt    = sin_q;
          ofs_k_nxt = 2'd0;
          state_nxt = S_OFS;
        end
      end
      S_OFS: begin
        case (ofs_k_r)
          2'd0:    p1x_nxt = p0x_r + ofs;
          2'd1:    p1y_nxt = p0y_r + ofs;
          2'd2:    p2x_nxt = p3x_r - ofs;
          default: p2y_nxt = p3y_r - ofs;
        endcase
        ofs_k_nxt = ofs_k_r + 2'd1;
        if (ofs_k_r == 2'd3) begin
          idx_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        w0x_nxt = p0x_r; w1x_nxt = p1x_r; w2x_nxt = p2x_r; w3x_nxt = p3x_r;
        w0y_nxt = p0y_r; w1y_nxt = p1y_r; w2y_nxt = p2y_r; w3y_nxt = p3y_r;
        step_nxt  = '0;
        state_nxt = S_LERP;
      end
      S_LERP: begin
        case (step_r)
          3'd1, 3'd4: begin
            w1x_nxt = lrx; w1y_nxt = lry;
          end
          3'd2: begin
            w2x_nxt = lrx; w2y_nxt = lry;
          end
          default: begin
            w0x_nxt = lrx; w0y_nxt = lry;
          end
        endcase
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd5) begin
          out_x_nxt     = sat_coord(lrx);
          out_y_nxt     = sat_coord(lry);
          out_idx_nxt   = idx_r;
          out_last_nxt  = (idx_r == LAST_IDX);
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold the point until the transaction completes
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (idx_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RESET;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_yaw_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_r      <= gain_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_yaw_r  <= prev_yaw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;   ay_r <= ay_nxt;   a2_r <= a2_nxt;   b2_r <= b2_nxt;
    len_r <= len_nxt; yaw0_r <= yaw0_nxt; yaw1_r <= yaw1_nxt;
    c0_r <= c0_nxt;   s0_r <= s0_nxt;   c1_r <= c1_nxt;   s1_r <= s1_nxt;
    p0x_r <= p0x_nxt; p1x_r <= p1x_nxt; p2x_r <= p2x_nxt; p3x_r <= p3x_nxt;
    p0y_r <= p0y_nxt; p1y_r <= p1y_nxt; p2y_r <= p2y_nxt; p3y_r <= p3y_nxt;
    w0x_r <= w0x_nxt; w1x_r <= w1x_nxt; w2x_r <= w2x_nxt; w3x_r <= w3x_nxt;
    w0y_r <= w0y_nxt; w1y_r <= w1y_nxt; w2y_r <= w2y_nxt; w3y_r <= w3y_nxt;
    idx_r <= idx_nxt; step_r <= step_nxt; ofs_k_r <= ofs_k_nxt;
    out_x_r <= out_x_nxt; out_y_r <= out_y_nxt;
    out_idx_r <= out_idx_nxt; out_last_r <= out_last_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_index = out_idx_r;
  assign out_last        = out_last_r;

endmodule

[hw/rtl/bzp_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzp_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bzp_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);
  import bzp_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      bit_nxt  = 64'd1 << 62;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

  assign root = res_r[31:0];
  assign done = done_r;

endmodule

[hw/rtl/bzp_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzp_cordic
// Iterative CORDIC sine and cosine of a binary angle, Q3.30 results.
// ----------------------------------------------------------------------------
module bzp_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [15:0]                       angle,
  output logic signed [bzp_pkg::TRIG_W-1:0] cos_q,
  output logic signed [bzp_pkg::TRIG_W-1:0] sin_q,
  output logic                              done
);
  import bzp_pkg::*;

  logic signed [TRIG_W-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [CSTEP_W-1:0]        cnt_r, cnt_nxt;
  logic                      neg_r, neg_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic signed [16:0]        a17, af;
  logic                      fold;
  logic signed [TRIG_W-1:0]  xs, ys, at;

  // fold to +-quarter turn, flip the result sign
  always_comb begin
    a17  = signed'({angle[15], angle});
    af   = a17;
    fold = 1'b0;
    if (a17 > 17'sd16384) begin
      af   = a17 - 17'sd32768;
      fold = 1'b1;
    end else if (a17 < -17'sd16384) begin
      af   = a17 + 17'sd32768;
      fold = 1'b1;
    end
  end

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = atan_lut(cnt_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = CORDIC_K;
      y_nxt    = '0;
      z_nxt    = signed'({af[16], af, 16'b0});
      cnt_nxt  = '0;
      neg_nxt  = fold;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + CSTEP_W'(1);
      if (cnt_r == CSTEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign cos_q = neg_r ? -x_r : x_r;
  assign sin_q = neg_r ? -y_r : y_r;
  assign done  = done_r;

endmodule

[hw/rtl/bzp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzp_checker
// Port-level checks of the Bezier path core, bound to the top level.
// ----------------------------------------------------------------------------
module bzp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [bzp_pkg::COORD_W-1:0] out_point_x,
  input logic signed [bzp_pkg::COORD_W-1:0] out_point_y,
  input logic [bzp_pkg::IDX_W-1:0]          out_point_index,
  input logic                               out_last
);
  import bzp_pkg::*;

  // a stalled result transaction holds its coordinates and index
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x) && $stable(out_point_y)
      && $stable(out_point_index))
    else $error("stalled result changed");

  // no new goal is taken while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while a result is pending");

  // an accepted goal stalls the input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input ready right after a goal transaction");

  // last flag marks exactly the final sample
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_point_index == LAST_IDX)))
    else $error("last flag does not match sample index");

  // the next sample needs the lerp steps; no back-to-back results
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result valid right after a transaction");

endmodule

bind pose_to_pose_bezier_path_core bzp_checker u_bzp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_point_x     (out_point_x),
  .out_point_y     (out_point_y),
  .out_point_index (out_point_index),
  .out_last        (out_last)
);
